// ===== hw/rtl/grcd_pkg.sv =====
// ----------------------------------------------------------------------------
// grcd_pkg: shared types and constants of the grid ray caster
// payload structs, sine polynomial coefficients and fixed-point constants
// ----------------------------------------------------------------------------
package grcd_pkg;

    // input transfer payload
    typedef struct packed {
        logic        command;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic [11:0] ray_angle;
        logic [13:0] origin_x;
        logic [13:0] origin_y;
    } grcd_in_t;

    // output transfer payload
    typedef struct packed {
        logic [15:0] wall_distance;
        logic        hit_found;
        logic        hit_side;
        logic [3:0]  hit_column;
        logic [3:0]  hit_row;
    } grcd_out_t;

    // command codes
    localparam logic CMD_ROW_WRITE = 1'b0;
    localparam logic CMD_CAST      = 1'b1;

    // register reset, 20.0 in Q6.10
    localparam logic [15:0] FAR_RESET = 16'd20480;

    // quarter-wave sine polynomial coefficients, Q16
    localparam logic [17:0] SIN_C1 = 18'd102944;
    localparam logic [17:0] SIN_C3 = 18'd42334;
    localparam logic [17:0] SIN_C5 = 18'd5223;
    localparam logic [17:0] SIN_C7 = 18'd307;
    localparam logic [17:0] SIN_C9 = 18'd11;

    // one in Q1.14
    localparam logic [17:0] ONE_Q14 = 18'd16384;

    // saturated step length for a zero direction component
    localparam logic [31:0] DELTA_SAT = 32'hFFFF_FFFF;

    // reciprocal quotient bits, 2^24 / m
    localparam int unsigned QUO_BITS = 25;

endpackage

// ===== hw/rtl/grid_ray_cast_dda.sv =====
// ----------------------------------------------------------------------------
// grid_ray_cast_dda: wall grid ray caster with DDA stepping
// holds a wall grid and walks a ray through it cell by cell
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall / in_data): a row write replaces one
//   grid row and gives no result; a cast gives one result on the output
//   channel (out_valid / out_stall / out_data).
//   cfg_we / cfg_wdata write the far distance reported when a ray leaves
//   the grid; write it only while the block is idle.
// timing
//   a cast runs on one shared multiplier and a bit-serial divider under a
//   small sequencer: per axis a sine polynomial, a reciprocal division and
//   a side distance step (both skipped for a zero component), then one DDA
//   step per cycle while the result slot is free, up to MAX_STEPS steps.
//   in_stall is high for the whole cast.
// reset
//   clears the grid to open, the far distance to 20.0 and all control.
// stalls
//   a finished result waits in the output register; a new transfer is taken
//   meanwhile, and the next cast freezes its walk until the slot frees.
// ----------------------------------------------------------------------------
module grid_ray_cast_dda
    import grcd_pkg::*;
#(
    parameter int GRID_CELLS = 16,
    parameter int MAX_STEPS  = 50,
    parameter int ANGLE_BITS = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  grcd_in_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output grcd_out_t        out_data,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata
);

    localparam int GRID_ROWS = (GRID_CELLS < 16) ? GRID_CELLS : 16;
    localparam int RIW       = $clog2(GRID_ROWS);
    localparam int SCW       = $clog2(MAX_STEPS + 1);
    localparam int QW        = ANGLE_BITS - 2;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SINE    = 6'b000010,
        S_DIV     = 6'b000100,
        S_SIDE    = 6'b001000,
        S_SIDE_WB = 6'b010000,
        S_WALK    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [15:0]         grid_reg [GRID_ROWS];
    logic [15:0]         far_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [13:0]         px_reg, py_reg;
    logic                axis_reg;
    logic [2:0]          sub_reg;
    logic [41:0]         prod_reg;
    logic [16:0]         t2_reg;
    logic [14:0]         mag_reg;
    logic                neg_x_reg, neg_y_reg;
    logic [15:0]         rem_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [4:0]          div_cnt_reg;
    logic [31:0]         delta_x_reg, delta_y_reg;
    logic [33:0]         side_x_reg, side_y_reg;
    logic signed [7:0]   mx_reg, my_reg;
    logic [SCW-1:0]      step_cnt_reg;
    logic                out_valid_reg;
    grcd_out_t           out_reg;

    logic                in_take;
    logic                out_hold;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_hold  = out_valid_reg && out_stall;

    // angle of the current axis: cosine is the sine a quarter turn on
    logic [27:0]           ang_ext;
    logic [ANGLE_BITS-1:0] ang_in;
    logic [ANGLE_BITS-1:0] ang_axis;
    logic [1:0]            quad;
    logic [QW-1:0]         qpos;
    logic [QW:0]           sin_idx;
    logic [16:0]           t_val;

    assign ang_ext  = {16'd0, in_data.ray_angle};
    assign ang_in   = ang_ext[ANGLE_BITS-1:0];
    assign ang_axis = axis_reg ? angle_reg
                               : angle_reg + ANGLE_BITS'(1 << QW);
    assign quad     = ang_axis[ANGLE_BITS-1 -: 2];
    assign qpos     = ang_axis[QW-1:0];
    assign sin_idx  = quad[0] ? ((QW+1)'(1 << QW) - {1'b0, qpos}) : {1'b0, qpos};
    assign t_val    = 17'({sin_idx, {(18 - ANGLE_BITS){1'b0}}});

    // horner term and multiplier operand selection
    logic [17:0] horner_coef;
    logic [17:0] p_val;
    logic [16:0] mul_a;
    logic [24:0] mul_b;
    logic [41:0] mul_p;

    always_comb
    begin
        case (sub_reg)
            3'd2:    horner_coef = SIN_C7;
            3'd3:    horner_coef = SIN_C5;
            3'd4:    horner_coef = SIN_C3;
            default: horner_coef = SIN_C1;
        endcase
    end

    assign p_val = horner_coef - prod_reg[33:16];

    // fraction to the next grid line for the current axis
    logic [9:0]  frac_raw;
    logic        neg_axis;
    logic [10:0] frac_val;
    logic [31:0] delta_axis;

    assign frac_raw   = axis_reg ? py_reg[9:0] : px_reg[9:0];
    assign neg_axis   = axis_reg ? neg_y_reg : neg_x_reg;
    assign frac_val   = neg_axis ? {1'b0, frac_raw} : (11'd1024 - {1'b0, frac_raw});
    assign delta_axis = axis_reg ? delta_y_reg : delta_x_reg;

    always_comb
    begin
        mul_a = t_val;
        mul_b = {8'd0, t_val};
        if (state_reg == S_SIDE)
        begin
            mul_a = {6'd0, frac_val};
            mul_b = delta_axis[24:0];
        end
        else
        begin
            case (sub_reg)
                3'd0:    begin mul_a = t_val;           mul_b = {8'd0, t_val}; end
                3'd1:    begin mul_a = prod_reg[32:16]; mul_b = {7'd0, SIN_C9}; end
                3'd5:    begin mul_a = t_val;           mul_b = {7'd0, p_val}; end
                default: begin mul_a = t2_reg;          mul_b = {7'd0, p_val}; end
            endcase
        end
    end

    // the shared multiplier
    assign mul_p = 42'(mul_a) * 42'(mul_b);

    // sine rounding to Q14 with cap
    logic [25:0] s_raw;
    logic [17:0] s_rnd;
    logic [14:0] mag_val;
    logic        neg_val;

    assign s_raw   = prod_reg[41:16] + 26'd2;
    assign s_rnd   = 18'(s_raw >> 2);
    assign mag_val = (s_rnd > ONE_Q14) ? 15'(ONE_Q14) : s_rnd[14:0];
    assign neg_val = quad[1] && (mag_val != 15'd0);

    // restoring divider step for 2^24 / m
    logic [15:0] rem_shift;
    logic        div_ge;
    logic [QUO_BITS-1:0] quo_shift;

    assign rem_shift = {rem_reg[14:0], (div_cnt_reg == 5'(QUO_BITS - 1))};
    assign div_ge    = (rem_shift >= {1'b0, mag_reg});
    assign quo_shift = {quo_reg[QUO_BITS-2:0], div_ge};

    // dda step
    logic               take_x;
    logic signed [7:0]  nmx, nmy;
    logic               oob;
    logic               wall;
    logic               last_step;
    logic [33:0]        side_prev;
    logic [15:0]        dist_sat;
    logic [15:0]        row_sel;

    assign take_x = (side_x_reg < side_y_reg);
    assign nmx    = take_x ? (neg_x_reg ? mx_reg - 8'sd1 : mx_reg + 8'sd1) : mx_reg;
    assign nmy    = take_x ? my_reg : (neg_y_reg ? my_reg - 8'sd1 : my_reg + 8'sd1);
    assign oob    = (nmx < 8'sd0) || (nmx >= 8'(GRID_CELLS))
                 || (nmy < 8'sd0) || (nmy >= 8'(GRID_CELLS));
    assign row_sel = (nmy < 8'(GRID_ROWS)) ? grid_reg[nmy[RIW-1:0]] : 16'd0;
    assign wall   = !oob && (nmx < 8'sd16) && row_sel[nmx[3:0]];
    assign last_step = (step_cnt_reg == SCW'(MAX_STEPS - 1));
    assign side_prev = take_x ? side_x_reg : side_y_reg;
    assign dist_sat = (side_prev > 34'd65535) ? 16'hFFFF : side_prev[15:0];

    // grid rows and far distance register
    logic [6:0] row_ext;
    assign row_ext = {3'd0, in_data.row_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_ROWS; i++)
            begin
                grid_reg[i] <= '0;
            end
            far_reg <= FAR_RESET;
        end
        else
        begin
            if (in_take && in_data.command == CMD_ROW_WRITE && row_ext < 7'(GRID_CELLS))
            begin
                grid_reg[in_data.row_index[RIW-1:0]] <= in_data.row_bits;
            end
            if (cfg_we)
            begin
                far_reg <= cfg_wdata;
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take && in_data.command == CMD_CAST)
                    state_next = S_SINE;
            end
            S_SINE:
            begin
                if (sub_reg == 3'd6)
                begin
                    if (mag_val == 15'd0)
                        state_next = axis_reg ? S_WALK : S_SINE;
                    else
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == 5'd0)
                    state_next = S_SIDE;
            end
            S_SIDE:
            begin
                state_next = S_SIDE_WB;
            end
            S_SIDE_WB:
            begin
                state_next = axis_reg ? S_WALK : S_SINE;
            end
            S_WALK:
            begin
                if (!out_hold && (oob || wall || last_step))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
            axis_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            step_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // result slot: filled by the final walk step, freed by a transfer
            if (state_reg == S_WALK && !out_hold && (oob || wall || last_step))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    sub_reg  <= '0;
                    axis_reg <= 1'b0;
                end
                S_SINE:
                begin
                    if (sub_reg == 3'd6)
                    begin
                        sub_reg     <= '0;
                        div_cnt_reg <= 5'(QUO_BITS - 1);
                        if (mag_val == 15'd0)
                        begin
                            axis_reg     <= 1'b1;
                            step_cnt_reg <= '0;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                end
                S_SIDE:
                begin
                end
                S_SIDE_WB:
                begin
                    axis_reg     <= 1'b1;
                    step_cnt_reg <= '0;
                end
                S_WALK:
                begin
                    if (!out_hold)
                    begin
                        step_cnt_reg <= step_cnt_reg + SCW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (in_take)
        begin
            angle_reg <= ang_in;
            px_reg    <= in_data.origin_x;
            py_reg    <= in_data.origin_y;
            mx_reg    <= 8'(in_data.origin_x[13:10]);
            my_reg    <= 8'(in_data.origin_y[13:10]);
        end
        if (state_reg == S_SINE)
        begin
            if (sub_reg == 3'd1)
                t2_reg <= prod_reg[32:16];
            if (sub_reg == 3'd6)
            begin
                mag_reg <= mag_val;
                rem_reg <= '0;
                if (axis_reg)
                    neg_y_reg <= neg_val;
                else
                    neg_x_reg <= neg_val;
                if (mag_val == 15'd0)
                begin
                    if (axis_reg)
                    begin
                        delta_y_reg <= DELTA_SAT;
                        side_y_reg  <= 34'(DELTA_SAT);
                    end
                    else
                    begin
                        delta_x_reg <= DELTA_SAT;
                        side_x_reg  <= 34'(DELTA_SAT);
                    end
                end
            end
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= div_ge ? (rem_shift - {1'b0, mag_reg}) : rem_shift;
            quo_reg <= quo_shift;
            if (div_cnt_reg == 5'd0)
            begin
                if (axis_reg)
                    delta_y_reg <= 32'(quo_shift);
                else
                    delta_x_reg <= 32'(quo_shift);
            end
        end
        if (state_reg == S_SIDE_WB)
        begin
            if (axis_reg)
                side_y_reg <= {2'd0, prod_reg[41:10]};
            else
                side_x_reg <= {2'd0, prod_reg[41:10]};
        end
        if (state_reg == S_WALK && !out_hold)
        begin
            mx_reg <= nmx;
            my_reg <= nmy;
            if (take_x)
                side_x_reg <= side_x_reg + {2'd0, delta_x_reg};
            else
                side_y_reg <= side_y_reg + {2'd0, delta_y_reg};
            out_reg.hit_side <= !take_x;
            if (oob)
            begin
                out_reg.wall_distance <= far_reg;
                out_reg.hit_found     <= 1'b1;
                out_reg.hit_column    <= nmx[3:0];
                out_reg.hit_row       <= nmy[3:0];
            end
            else if (wall)
            begin
                out_reg.wall_distance <= dist_sat;
                out_reg.hit_found     <= 1'b1;
                out_reg.hit_column    <= nmx[3:0];
                out_reg.hit_row       <= nmy[3:0];
            end
            else
            begin
                out_reg.wall_distance <= '0;
                out_reg.hit_found     <= 1'b0;
                out_reg.hit_column    <= '0;
                out_reg.hit_row       <= '0;
            end
        end
    end

    // checks
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (step_cnt_reg < SCW'(MAX_STEPS)))
        else $error("dda step count beyond limit");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (mag_reg != 15'd0))
        else $error("division started with zero component");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && $past(state_reg) == S_WALK && out_hold)
        |=> $stable(step_cnt_reg) || !$past(out_hold))
        else $error("walk advanced while result slot full");

endmodule
